@@ design/interrupt_line_remap_table_assert.svh @@
// Assertion macros for the interrupt line remap table checks
`ifndef INTERRUPT_LINE_REMAP_TABLE_ASSERT_SVH
`define INTERRUPT_LINE_REMAP_TABLE_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define ILRT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define ILRT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ilrt_pkg.sv @@
// Shared types and constants for the interrupt line remap table
`default_nettype none
package ilrt_pkg;

  localparam int FIELD_W  = 6;
  localparam int STATES_W = 64;

  localparam logic [1:0] FUNC_MAP    = 2'd0;
  localparam logic [1:0] FUNC_UNMAP  = 2'd1;
  localparam logic [1:0] FUNC_UPDATE = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  typedef struct packed {
    logic load;
    logic clear;
    logic map_exec;
    logic unm_rd_h;
    logic unm_head_fix;
    logic unm_walk_start;
    logic unm_walk_step;
    logic unm_link;
    logic upd_start;
    logic upd_step;
    logic emit_ack;
    logic emit_drive;
  } dp_cmd_t;

  typedef struct packed {
    logic unm_ok;
    logic h_is_head;
    logic at_tail;
    logic succ_hit;
    logic list_empty;
  } dp_status_t;

endpackage
`default_nettype wire

@@ design/interrupt_line_remap_table.sv @@
// Top level of the interrupt line remap table
//
//  channel  | ports                                             | handshake
//  ---------+---------------------------------------------------+------------------------
//  item in  | func host_line target_line line_states            | start high, busy low
//  result   | out_line level drive_valid last                   | result_strobe, 1 cycle
//
// Clear completes in its accept cycle and gives no result. Map executes in S_MAP and
// its registered acknowledgment shows in the cycle after. Unmap checks the line, then
// fixes the head or walks the list until its predecessor is found, one successor-table
// read per step. Update acks an empty list, else gives one result per mapped line;
// results come one per cycle. Reset (rst, synchronous) empties the list; no clearing
// pass. Results cannot be stalled; busy is high until the final result is issued.
`default_nettype none
module interrupt_line_remap_table import ilrt_pkg::*; #(
  parameter int HOST_LINES  = 64,
  parameter int GUEST_LINES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          func,
  input  logic [FIELD_W-1:0]  host_line,
  input  logic [FIELD_W-1:0]  target_line,
  input  logic [STATES_W-1:0] line_states,
  output logic                result_strobe,
  output logic [FIELD_W-1:0]  out_line,
  output logic                level,
  output logic                drive_valid,
  output logic                last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ilrt_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ilrt_datapath #(
    .HOST_LINES  (HOST_LINES),
    .GUEST_LINES (GUEST_LINES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .host_line     (host_line),
    .target_line   (target_line),
    .line_states   (line_states),
    .status        (status),
    .result_strobe (result_strobe),
    .out_line      (out_line),
    .level         (level),
    .drive_valid   (drive_valid),
    .last          (last)
  );

endmodule
`default_nettype wire

@@ design/ilrt_datapath.sv @@
// Datapath: entry tables, list pointers and result registers
`default_nettype none
module ilrt_datapath import ilrt_pkg::*; #(
  parameter int HOST_LINES  = 64,
  parameter int GUEST_LINES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  input  logic [FIELD_W-1:0]  host_line,
  input  logic [FIELD_W-1:0]  target_line,
  input  logic [STATES_W-1:0] line_states,
  output dp_status_t          status,
  output logic                result_strobe,
  output logic [FIELD_W-1:0]  out_line,
  output logic                level,
  output logic                drive_valid,
  output logic                last
);

  localparam int IDX_W = $clog2(HOST_LINES);
  localparam int TGT_W = $clog2(GUEST_LINES);
  localparam logic [FIELD_W:0] HOST_LIM  = (FIELD_W+1)'(HOST_LINES);
  localparam logic [FIELD_W:0] GUEST_LIM = (FIELD_W+1)'(GUEST_LINES);

  logic [IDX_W-1:0]    succ_mem [HOST_LINES];
  logic [TGT_W-1:0]    tgt_mem  [HOST_LINES];

  logic [FIELD_W-1:0]  op_host;
  logic [FIELD_W-1:0]  op_tgt;
  logic [STATES_W-1:0] op_states;
  logic [IDX_W-1:0]    head;
  logic [IDX_W-1:0]    tail;
  logic                empty;
  logic [HOST_LINES-1:0] valid;
  logic [IDX_W-1:0]    ptr;
  logic [IDX_W-1:0]    hsucc;
  logic [IDX_W-1:0]    succ_q;
  logic [TGT_W-1:0]    tgt_q;

  logic [IDX_W-1:0]    h_idx;
  logic [TGT_W-1:0]    t_idx;
  logic                h_in;
  logic                t_in;
  logic                map_ok;
  logic                map_new;
  logic [IDX_W-1:0]    rd_addr;
  logic                succ_we;
  logic [IDX_W-1:0]    succ_waddr;
  logic [IDX_W-1:0]    succ_wdata;
  logic                tgt_we;

  assign h_idx   = op_host[IDX_W-1:0];
  assign t_idx   = op_tgt[TGT_W-1:0];
  assign h_in    = {1'b0, op_host} < HOST_LIM;
  assign t_in    = {1'b0, op_tgt} < GUEST_LIM;
  assign map_ok  = h_in && t_in;
  assign map_new = map_ok && !valid[h_idx];

  assign status.unm_ok     = h_in && valid[h_idx] && !empty;
  assign status.h_is_head  = (h_idx == head);
  assign status.at_tail    = (ptr == tail);
  assign status.succ_hit   = (succ_q == h_idx);
  assign status.list_empty = empty;

  always_comb begin
    rd_addr = ptr;
    if (cmd.unm_rd_h) begin
      rd_addr = h_idx;
    end else if (cmd.unm_walk_start || cmd.upd_start) begin
      rd_addr = head;
    end else if (cmd.unm_walk_step || cmd.upd_step) begin
      rd_addr = succ_q;
    end
  end

  // successor of the tail is never used, so a new tail needs no write of its own
  assign succ_we    = (cmd.map_exec && map_new && !empty) || cmd.unm_link;
  assign succ_waddr = cmd.unm_link ? ptr : tail;
  assign succ_wdata = cmd.unm_link ? hsucc : h_idx;
  assign tgt_we     = cmd.map_exec && map_ok;

  always_ff @(posedge clk) begin
    succ_q <= succ_mem[rd_addr];
    tgt_q  <= tgt_mem[rd_addr];
    if (succ_we) begin
      succ_mem[succ_waddr] <= succ_wdata;
    end
    if (tgt_we) begin
      tgt_mem[h_idx] <= t_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      tail          <= '0;
      empty         <= 1'b1;
      valid         <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit_ack || cmd.emit_drive;
      if (cmd.clear) begin
        valid <= '0;
        head  <= '0;
        tail  <= '0;
        empty <= 1'b1;
      end
      if (cmd.map_exec && map_new) begin
        valid[h_idx] <= 1'b1;
        if (empty) begin
          head  <= h_idx;
          empty <= 1'b0;
        end
        tail <= h_idx;
      end
      if (cmd.unm_rd_h) begin
        valid[h_idx] <= 1'b0;
      end
      if (cmd.unm_head_fix) begin
        if (h_idx == tail) begin
          empty <= 1'b1;
          head  <= '0;
          tail  <= '0;
        end else begin
          head <= succ_q;
        end
      end
      if (cmd.unm_link && (h_idx == tail)) begin
        tail <= ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_host   <= host_line;
      op_tgt    <= target_line;
      op_states <= line_states;
    end
    if (cmd.unm_walk_start || cmd.upd_start) begin
      ptr <= head;
    end else if (cmd.unm_walk_step || cmd.upd_step) begin
      ptr <= succ_q;
    end
    if (cmd.unm_walk_start) begin
      hsucc <= succ_q;
    end
    if (cmd.emit_ack) begin
      out_line    <= '0;
      level       <= 1'b0;
      drive_valid <= 1'b0;
      last        <= 1'b1;
    end else if (cmd.emit_drive) begin
      out_line    <= FIELD_W'(tgt_q);
      level       <= op_states[ptr];
      drive_valid <= 1'b1;
      last        <= (ptr == tail);
    end
  end

endmodule
`default_nettype wire

@@ design/ilrt_controller.sv @@
// Controller: sequences map, unmap, update and clear items
`default_nettype none
module ilrt_controller import ilrt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] func,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_MAP       = 3'd1;
  localparam logic [2:0] S_UNM_CHK   = 3'd2;
  localparam logic [2:0] S_UNM_HEAD  = 3'd3;
  localparam logic [2:0] S_UNM_WALK  = 3'd4;
  localparam logic [2:0] S_UPD_START = 3'd5;
  localparam logic [2:0] S_UPD_EMIT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (func)
            FUNC_MAP:    state_next = S_MAP;
            FUNC_UNMAP:  state_next = S_UNM_CHK;
            FUNC_UPDATE: state_next = S_UPD_START;
            FUNC_CLEAR:  cmd.clear  = 1'b1;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_MAP: begin
        cmd.map_exec = 1'b1;
        cmd.emit_ack = 1'b1;
        state_next   = S_IDLE;
      end
      S_UNM_CHK: begin
        if (status.unm_ok) begin
          cmd.unm_rd_h = 1'b1;
          state_next   = S_UNM_HEAD;
        end else begin
          cmd.emit_ack = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_UNM_HEAD: begin
        if (status.h_is_head) begin
          cmd.unm_head_fix = 1'b1;
          cmd.emit_ack     = 1'b1;
          state_next       = S_IDLE;
        end else begin
          cmd.unm_walk_start = 1'b1;
          state_next         = S_UNM_WALK;
        end
      end
      S_UNM_WALK: begin
        if (status.at_tail) begin
          cmd.emit_ack = 1'b1;
          state_next   = S_IDLE;
        end else if (status.succ_hit) begin
          cmd.unm_link = 1'b1;
          cmd.emit_ack = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.unm_walk_step = 1'b1;
        end
      end
      S_UPD_START: begin
        if (status.list_empty) begin
          cmd.emit_ack = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.upd_start = 1'b1;
          state_next    = S_UPD_EMIT;
        end
      end
      S_UPD_EMIT: begin
        cmd.emit_drive = 1'b1;
        if (status.at_tail) begin
          state_next = S_IDLE;
        end else begin
          cmd.upd_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ design/ilrt_checker.sv @@
// Port-level checks for the interrupt line remap table, bound to the top level
`default_nettype none
`include "interrupt_line_remap_table_assert.svh"
module ilrt_checker import ilrt_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         func,
  input logic               result_strobe,
  input logic [FIELD_W-1:0] out_line,
  input logic               level,
  input logic               drive_valid,
  input logic               last
);

  logic accepted;
  assign accepted = start && !busy;

  `ILRT_ASSERT_NEXT(a_busy_after_item, clk, rst, accepted && (func != FUNC_CLEAR), busy, "item with results did not raise busy")
  `ILRT_ASSERT_NEXT(a_clear_silent, clk, rst, accepted && (func == FUNC_CLEAR), !result_strobe, "clear gave a result")
  `ILRT_ASSERT_NOW(a_ack_shape, clk, rst, result_strobe && !drive_valid, (out_line == '0) && !level && last, "acknowledgment fields not clear")
  `ILRT_ASSERT_NOW(a_last_idle, clk, rst, result_strobe && last, !busy, "busy after final item result")

endmodule

bind interrupt_line_remap_table ilrt_checker u_chk (.*);
`default_nettype wire

@@ bench/interrupt_line_remap_table_test.sv @@
// Self-checking testbench for the interrupt line remap table: directed and random items, scoreboard
`timescale 1ns / 100ps
module interrupt_line_remap_table_test;
  import ilrt_pkg::*;

  localparam int LINES          = 64;
  localparam int RANDOM_ITEMS   = 85;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [FIELD_W-1:0] line;
    logic               lvl;
    logic               dv;
    logic               lst;
  } drive_result_t;

  class remap_scoreboard;
    bit                 mapped[LINES];
    logic [FIELD_W-1:0] guest_of[LINES];
    logic [FIELD_W-1:0] next_of[LINES];
    logic [FIELD_W-1:0] head;
    logic [FIELD_W-1:0] tail;
    bit                 empty = 1'b1;
    drive_result_t      pending[$];
    int                 errors;

    function void note_item(logic [1:0] f, logic [FIELD_W-1:0] h, logic [FIELD_W-1:0] t,
                            logic [STATES_W-1:0] s);
      logic [FIELD_W-1:0] p;
      bit                 done;
      case (f)
        FUNC_MAP: begin
          guest_of[h] = t;
          if (!mapped[h]) begin
            mapped[h]  = 1'b1;
            next_of[h] = '0;
            if (empty) begin
              head  = h;
              empty = 1'b0;
            end else begin
              next_of[tail] = h;
            end
            tail = h;
          end
          pending.push_back('{line: '0, lvl: 1'b0, dv: 1'b0, lst: 1'b1});
        end
        FUNC_UNMAP: begin
          if (mapped[h] && !empty) begin
            mapped[h] = 1'b0;
            if (h == head) begin
              if (h == tail) begin
                empty = 1'b1;
                head  = '0;
                tail  = '0;
              end else begin
                head = next_of[h];
              end
            end else begin
              p = head;
              for (int n = 0; n < LINES; n++) begin
                if (p == tail) break;
                if (next_of[p] == h) begin
                  next_of[p] = next_of[h];
                  if (h == tail) tail = p;
                  break;
                end
                p = next_of[p];
              end
            end
          end
          pending.push_back('{line: '0, lvl: 1'b0, dv: 1'b0, lst: 1'b1});
        end
        FUNC_UPDATE: begin
          if (empty) begin
            pending.push_back('{line: '0, lvl: 1'b0, dv: 1'b0, lst: 1'b1});
          end else begin
            p = head;
            for (int n = 0; n < LINES; n++) begin
              done = (p == tail) || (n == LINES - 1);
              pending.push_back('{line: guest_of[p], lvl: s[p], dv: 1'b1, lst: done});
              if (done) break;
              p = next_of[p];
            end
          end
        end
        default: begin
          foreach (mapped[k]) mapped[k] = 1'b0;
          head  = '0;
          tail  = '0;
          empty = 1'b1;
        end
      endcase
    endfunction

    function void check_result(logic [FIELD_W-1:0] line, logic lvl, logic dv, logic lst);
      drive_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: out_line %0d level %0b drive_valid %0b last %0b",
               line, lvl, dv, lst);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want.line !== line) begin
        $error("out_line: expected %0d actual %0d", want.line, line);
        errors++;
      end
      if (want.lvl !== lvl) begin
        $error("level: expected %0b actual %0b", want.lvl, lvl);
        errors++;
      end
      if (want.dv !== dv) begin
        $error("drive_valid: expected %0b actual %0b", want.dv, dv);
        errors++;
      end
      if (want.lst !== lst) begin
        $error("last: expected %0b actual %0b", want.lst, lst);
        errors++;
      end
    endfunction

    // favours live entries so unmaps and remaps hit head, middle and tail
    function int pick_mapped();
      int live[$];
      foreach (mapped[k]) if (mapped[k]) live.push_back(k);
      if (live.size() == 0) return $urandom_range(0, LINES - 1);
      return live[$urandom_range(0, live.size() - 1)];
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          func = FUNC_MAP;
  logic [FIELD_W-1:0]  host_line = '0;
  logic [FIELD_W-1:0]  target_line = '0;
  logic [STATES_W-1:0] line_states = '0;
  logic                result_strobe;
  logic [FIELD_W-1:0]  out_line;
  logic                level;
  logic                drive_valid;
  logic                last;

  remap_scoreboard board = new;
  int              idle_cycles = 0;

  interrupt_line_remap_table dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .host_line    (host_line),
    .target_line  (target_line),
    .line_states  (line_states),
    .result_strobe(result_strobe),
    .out_line     (out_line),
    .level        (level),
    .drive_valid  (drive_valid),
    .last         (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe) board.check_result(out_line, level, drive_valid, last);
      if (start && !busy) board.note_item(func, host_line, target_line, line_states);
      if (result_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic [1:0] f, logic [FIELD_W-1:0] h, logic [FIELD_W-1:0] t,
                           logic [STATES_W-1:0] s);
    start       <= 1'b1;
    func        <= f;
    host_line   <= h;
    target_line <= t;
    line_states <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random_item();
    int                 w;
    logic [1:0]         f;
    logic [FIELD_W-1:0] h;
    w = $urandom_range(0, 99);
    if (w < 48) f = FUNC_MAP;
    else if (w < 70) f = FUNC_UNMAP;
    else if (w < 96) f = FUNC_UPDATE;
    else f = FUNC_CLEAR;
    h = FIELD_W'($urandom_range(0, LINES - 1));
    if (f == FUNC_UNMAP && $urandom_range(0, 3) != 0) h = FIELD_W'(board.pick_mapped());
    if (f == FUNC_MAP && $urandom_range(0, 4) == 0) h = FIELD_W'(board.pick_mapped());
    send_item(f, h, FIELD_W'($urandom_range(0, LINES - 1)), {$urandom, $urandom});
  endtask

  initial begin
    int sent;
    int burst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_item(FUNC_UPDATE, 6'd0, 6'd0, '1);                    // empty list
    send_item(FUNC_UNMAP, 6'd5, 6'd0, '0);                     // line not mapped
    send_item(FUNC_CLEAR, 6'd63, 6'd63, '1);
    send_item(FUNC_MAP, 6'd0, 6'd63, '0);
    send_item(FUNC_MAP, 6'd63, 6'd0, '0);
    send_item(FUNC_MAP, 6'd21, 6'd42, '1);
    send_item(FUNC_UPDATE, 6'd0, 6'd0, '1);
    send_item(FUNC_MAP, 6'd21, 6'd7, '0);                      // remap tail
    send_item(FUNC_MAP, 6'd0, 6'd33, '0);                      // remap head
    send_item(FUNC_MAP, 6'd42, 6'd21, '0);
    send_item(FUNC_UPDATE, 6'd63, 6'd63, '0);
    send_item(FUNC_UPDATE, 6'd0, 6'd0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(FUNC_UNMAP, 6'd63, 6'd0, '0);                    // middle entry
    send_item(FUNC_UPDATE, 6'd0, 6'd0, 64'h5555_5555_5555_5555);
    send_item(FUNC_UNMAP, 6'd42, 6'd0, '0);                    // tail entry
    send_item(FUNC_MAP, 6'd63, 6'd1, '0);
    send_item(FUNC_UNMAP, 6'd0, 6'd0, '0);                     // head entry
    send_item(FUNC_UPDATE, 6'd0, 6'd0, '1);
    send_item(FUNC_UNMAP, 6'd21, 6'd0, '0);
    send_item(FUNC_UNMAP, 6'd63, 6'd0, '0);                    // sole entry
    send_item(FUNC_UPDATE, 6'd0, 6'd0, '1);
    send_item(FUNC_MAP, 6'd9, 6'd9, '0);
    send_item(FUNC_MAP, 6'd10, 6'd10, '0);
    send_item(FUNC_CLEAR, 6'd0, 6'd0, '0);
    send_item(FUNC_UPDATE, 6'd0, 6'd0, '1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 10);
      repeat (burst) begin
        send_random_item();
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
